@@ sv/rgbd_pkg.sv @@
// rgbd_pkg: shared types and constants of the button rgb dimmer control
// no dependencies; imported by button_rgb_dimmer_control_top
`default_nettype none

package rgbd_pkg;

  // width of the millisecond time base, arithmetic wraps at this width
  localparam int TIME_BITS = 32;

  localparam int DUTY_W = 7;
  localparam int CFG_W  = 16;
  localparam int CH_W   = 2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [DUTY_W-1:0]    duty_t;
  typedef logic [CH_W-1:0]      chan_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HOLDOFF    = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DUTY_STEP  = 2'd2,
    REG_DUTY_MAX   = 2'd3
  } reg_idx_t;

  // channel codes
  localparam chan_t CH_RED   = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

  // reset values
  localparam logic [CFG_W-1:0] HOLDOFF_RST    = 16'd0;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd600;
  localparam duty_t            DUTY_STEP_RST  = 7'd10;
  localparam duty_t            DUTY_MAX_RST   = 7'd100;
  localparam duty_t            DUTY_RST       = 7'd100;
  localparam time_t            LAST_ACCEPT_RST = time_t'(50);

  // one result item
  typedef struct packed {
    duty_t red;
    duty_t green;
    duty_t blue;
    chan_t sel;
    logic  accepted;
  } res_t;

endpackage

`default_nettype wire

@@ sv/button_rgb_dimmer_control_top.sv @@
// button_rgb_dimmer_control_top: button edge decoder, channel select and duty stepping
// depends on rgbd_pkg for types, register indexes and reset values
`default_nettype none

// Takes one button edge per item, each with its millisecond time stamp, and
// returns one result item per edge: the three channel duties, the selected
// channel and whether the edge passed the hold-off check. An item is
// accepted in every cycle with in_stall low; its result goes to the result register,
// or to the skid register while that one is held. The state update is a single
// pass of compares and adds on the accepted item, so that sets the rate of one item
// per cycle while in_stall is low. A two-entry output buffer (result register plus
// skid register) keeps input accepting while one result waits; in_stall rises only
// when both entries are full. The user must write configuration registers through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does not check.
module button_rgb_dimmer_control_top
  import rgbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       in_event_time,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DUTY_W-1:0]      out_red_duty,
  output logic [DUTY_W-1:0]      out_green_duty,
  output logic [DUTY_W-1:0]      out_blue_duty,
  output logic [CH_W-1:0]        out_selected_channel,
  output logic                   out_edge_accepted
);

  // configuration
  logic [CFG_W-1:0] holdoff_r;
  logic [CFG_W-1:0] long_press_r;
  duty_t            duty_step_r;
  duty_t            duty_max_r;

  // control state
  logic   pressed_r;
  time_t  press_start_r;
  time_t  last_accept_r;
  chan_t  short_cnt_r;
  chan_t  sel_r;
  logic   step_up_r;
  duty_t  duty_r [3];

  // output buffer
  logic out_valid_r;
  res_t out_r;
  logic skid_valid_r;
  res_t skid_r;

  logic  in_fire;
  logic  out_fire;
  time_t now;
  time_t limit;
  time_t dur;
  logic  accepted;
  logic  is_long;
  chan_t ch;
  duty_t cur_duty;
  logic [DUTY_W:0] sum;
  duty_t stepped;
  logic  up_nxt_step;

  logic   pressed_nxt;
  time_t  press_start_nxt;
  time_t  last_accept_nxt;
  chan_t  short_cnt_nxt;
  chan_t  sel_nxt;
  logic   step_up_nxt;
  duty_t  duty_nxt [3];
  res_t   res;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  assign now      = time_t'(in_event_time);
  assign limit    = last_accept_r + time_t'(holdoff_r);
  assign accepted = !(now < limit);
  assign dur      = now - press_start_r;
  assign is_long  = dur > time_t'(long_press_r);
  assign ch       = (sel_r > CH_BLUE) ? CH_BLUE : sel_r;
  assign cur_duty = duty_r[ch];
  assign sum      = {1'b0, cur_duty} + {1'b0, duty_step_r};

  // saturating step in the shared direction
  always_comb begin
    if (step_up_r) begin
      if (sum < {1'b0, duty_max_r}) begin
        stepped     = sum[DUTY_W-1:0];
        up_nxt_step = 1'b1;
      end else begin
        stepped     = duty_max_r;
        up_nxt_step = 1'b0;
      end
    end else begin
      if (cur_duty > duty_step_r) begin
        stepped     = cur_duty - duty_step_r;
        up_nxt_step = 1'b0;
      end else begin
        stepped     = '0;
        up_nxt_step = 1'b1;
      end
    end
  end

  always_comb begin
    pressed_nxt     = pressed_r;
    press_start_nxt = press_start_r;
    last_accept_nxt = last_accept_r;
    short_cnt_nxt   = short_cnt_r;
    sel_nxt         = sel_r;
    step_up_nxt     = step_up_r;
    for (int i = 0; i < 3; i++) begin
      duty_nxt[i] = duty_r[i];
    end
    if (accepted) begin
      last_accept_nxt = now;
      if (!pressed_r) begin
        pressed_nxt     = 1'b1;
        press_start_nxt = now;
      end else begin
        pressed_nxt = 1'b0;
        if (!is_long) begin
          // count 0,1,2 picks red, green, blue, then moves on
          unique case (short_cnt_r)
            2'd0: begin
              sel_nxt       = CH_RED;
              short_cnt_nxt = 2'd1;
            end
            2'd1: begin
              sel_nxt       = CH_GREEN;
              short_cnt_nxt = 2'd2;
            end
            default: begin
              sel_nxt       = CH_BLUE;
              short_cnt_nxt = 2'd0;
            end
          endcase
        end else begin
          duty_nxt[ch] = stepped;
          step_up_nxt  = up_nxt_step;
        end
      end
    end
    res.red      = duty_nxt[0];
    res.green    = duty_nxt[1];
    res.blue     = duty_nxt[2];
    res.sel      = sel_nxt;
    res.accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r    <= HOLDOFF_RST;
      long_press_r <= LONG_PRESS_RST;
      duty_step_r  <= DUTY_STEP_RST;
      duty_max_r   <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HOLDOFF:    holdoff_r    <= cfg_wdata;
        REG_LONG_PRESS: long_press_r <= cfg_wdata;
        REG_DUTY_STEP:  duty_step_r  <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_MAX:   duty_max_r   <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r     <= 1'b0;
      press_start_r <= '0;
      last_accept_r <= LAST_ACCEPT_RST;
      short_cnt_r   <= '0;
      sel_r         <= CH_RED;
      step_up_r     <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        duty_r[i] <= DUTY_RST;
      end
    end else if (in_fire) begin
      pressed_r     <= pressed_nxt;
      press_start_r <= press_start_nxt;
      last_accept_r <= last_accept_nxt;
      short_cnt_r   <= short_cnt_nxt;
      sel_r         <= sel_nxt;
      step_up_r     <= step_up_nxt;
      for (int i = 0; i < 3; i++) begin
        duty_r[i] <= duty_nxt[i];
      end
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_red_duty         = out_r.red;
  assign out_green_duty       = out_r.green;
  assign out_blue_duty        = out_r.blue;
  assign out_selected_channel = out_r.sel;
  assign out_edge_accepted    = out_r.accepted;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r <= CH_BLUE)
    else $error("selected channel out of range");

  // every accepted edge flips the press state
  a_press_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && accepted) |=> (pressed_r != $past(pressed_r)))
    else $error("accepted edge did not toggle press state");

  // an item taken while the result is free shows next cycle
  a_item_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (!out_valid_r || out_fire)) |=> out_valid_r)
    else $error("accepted item did not reach result register");

endmodule

`default_nettype wire

@@ tb/button_rgb_dimmer_control_top_tb.sv @@
// button_rgb_dimmer_control_top_tb: self-checking bench for the button rgb dimmer control
// depends on rgbd_pkg and button_rgb_dimmer_control_top; predicts every result item
`timescale 1ns / 100ps

module button_rgb_dimmer_control_top_tb;
  import rgbd_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_HOLDOFF;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [31:0]       in_event_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DUTY_W-1:0] out_red_duty;
  logic [DUTY_W-1:0] out_green_duty;
  logic [DUTY_W-1:0] out_blue_duty;
  logic [CH_W-1:0]   out_selected_channel;
  logic              out_edge_accepted;

  button_rgb_dimmer_control_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_event_time        (in_event_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_red_duty         (out_red_duty),
    .out_green_duty       (out_green_duty),
    .out_blue_duty        (out_blue_duty),
    .out_selected_channel (out_selected_channel),
    .out_edge_accepted    (out_edge_accepted)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the dimmer state and registers
  logic [CFG_W-1:0] hold_ms;
  logic [CFG_W-1:0] long_ms;
  duty_t            step_sz;
  duty_t            duty_top;
  logic             btn_down;
  time_t            press_t0;
  time_t            last_edge_t;
  logic [1:0]       short_cnt;
  chan_t            chan_sel;
  logic             going_up;
  duty_t            duty_now [3];

  res_t  pending_duties [$];
  res_t  head;
  int    errors = 0;
  int    accepted_edges = 0;
  bit    idle_on = 1'b1;
  int    stall_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic reset_shadow();
    hold_ms     = HOLDOFF_RST;
    long_ms     = LONG_PRESS_RST;
    step_sz     = DUTY_STEP_RST;
    duty_top    = DUTY_MAX_RST;
    btn_down    = 1'b0;
    press_t0    = '0;
    last_edge_t = LAST_ACCEPT_RST;
    short_cnt   = 2'd0;
    chan_sel    = CH_RED;
    going_up    = 1'b1;
    for (int i = 0; i < 3; i++) duty_now[i] = DUTY_RST;
  endtask

  task automatic step_selected_duty();
    int    ch;
    duty_t d;
    ch = (chan_sel > CH_BLUE) ? int'(CH_BLUE) : int'(chan_sel);
    d = duty_now[ch];
    if (going_up) begin
      if (int'(d) + int'(step_sz) < int'(duty_top)) begin
        d = d + step_sz;
      end else begin
        d = duty_top;
        going_up = 1'b0;
      end
    end else if (d > step_sz) begin
      d = d - step_sz;
    end else begin
      d = '0;
      going_up = 1'b1;
    end
    duty_now[ch] = d;
  endtask

  // applies one button edge to the shadow and queues the result it must give
  task automatic predict_dimmer(input time_t stamp);
    time_t lim;
    logic  acc;
    lim = last_edge_t + time_t'(hold_ms);
    acc = !(stamp < lim);
    if (acc) begin
      accepted_edges++;
      if (!btn_down) begin
        btn_down = 1'b1;
        press_t0 = stamp;
      end else begin
        btn_down = 1'b0;
        if (stamp - press_t0 <= time_t'(long_ms)) begin
          case (short_cnt)
            2'd0: begin
              chan_sel  = CH_RED;
              short_cnt = 2'd1;
            end
            2'd1: begin
              chan_sel  = CH_GREEN;
              short_cnt = 2'd2;
            end
            default: begin
              chan_sel  = CH_BLUE;
              short_cnt = 2'd0;
            end
          endcase
        end else begin
          step_selected_duty();
        end
      end
      last_edge_t = stamp;
    end
    pending_duties.push_back('{red: duty_now[0], green: duty_now[1], blue: duty_now[2],
                               sel: chan_sel, accepted: acc});
  endtask

  task automatic push_edge(input time_t stamp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_event_time <= stamp;
    do @(posedge clk); while (in_stall);
    predict_dimmer(stamp);
  endtask

  // sender holds off until every result item is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] hold, input logic [15:0] lp,
                                input duty_t step, input duty_t top);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HOLDOFF;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    // bits above the 7-bit registers are junk and must be dropped
    cfg_index <= REG_DUTY_STEP;
    cfg_wdata <= {9'($urandom), step};
    @(posedge clk);
    cfg_index <= REG_DUTY_MAX;
    cfg_wdata <= {9'($urandom), top};
    @(posedge clk);
    cfg_we   <= 1'b0;
    hold_ms  = hold;
    long_ms  = lp;
    step_sz  = step;
    duty_top = top;
  endtask

  // next edge of a clean press/release sequence, short or long
  task automatic press_action(input bit go_long);
    time_t lim;
    time_t t;
    int    dur;
    lim = last_edge_t + time_t'(hold_ms);
    if (!btn_down) begin
      t = lim + time_t'($urandom_range(0, 2000));
    end else begin
      dur = go_long ? int'(long_ms) + 1 + $urandom_range(0, 3000)
                    : $urandom_range(0, long_ms);
      t = press_t0 + time_t'(dur);
      if (t < lim) t = lim;
    end
    push_edge(t);
  endtask

  task automatic random_edge();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      press_action($urandom_range(0, 99) < 55);
    end else if (r < 90 && hold_ms != 0) begin
      // bounce inside the hold-off window
      push_edge(last_edge_t + time_t'($urandom_range(0, hold_ms - 1)));
    end else begin
      push_edge(time_t'($urandom_range(0, last_edge_t)));
    end
  endtask

  task automatic test_reset_behaviour();
    push_edge(32'd0);     // below the reset accept time
    push_edge(32'd49);
    push_edge(32'd50);    // exactly at the limit
    push_edge(32'd650);   // 600 ms is still short, first short press keeps red
    push_edge(32'd700);
    push_edge(32'd1301);  // long press saturates red at the top
    push_edge(32'd1400);
    push_edge(32'd2000);
    push_edge(32'd2100);
    push_edge(32'd2800);  // long press on green steps down
    push_edge(32'd2900);
    push_edge(32'd3000);
    push_edge(32'd3100);
    push_edge(32'd3200);  // fourth short press goes back to red
    settle();
  endtask

  task automatic test_time_wrap();
    apply_settings(16'h0200, LONG_PRESS_RST, DUTY_STEP_RST, DUTY_MAX_RST);
    push_edge(32'hFFFF_FF00);
    push_edge(32'h0000_0010);  // inside the wrapped hold-off window
    push_edge(32'h0000_0150);  // press spans the wrap
    push_edge(32'hFFFF_FFFF);
    push_edge(32'h0000_0300);
    settle();
  endtask

  task automatic test_press_sequences();
    int phase;
    int goal;
    phase = 0;
    push_edge(32'hC000_0000 + time_t'($urandom_range(0, 32'h00FF_FFFF)));
    while (accepted_edges < 900) begin
      settle();
      idle_on = ($urandom_range(0, 3) != 0);
      case (phase)
        0: apply_settings(16'd0, 16'd0, 7'd1, 7'd1);
        1: apply_settings(16'hFFFF, 16'hFFFF, 7'd100, 7'd100);
        2: apply_settings(16'd0, 16'd600, 7'd0, 7'd127);
        3: apply_settings(16'd20, 16'd300, 7'd127, 7'd0);
        4: apply_settings(16'd5, 16'd200, 7'd7, 7'd100);
        default: apply_settings(
          ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 200)),
          16'($urandom_range(0, 1500)),
          ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 100)),
          ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 100)));
      endcase
      goal = accepted_edges + $urandom_range(60, 120);
      while (accepted_edges < goal) random_edge();
      phase++;
    end
    settle();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    apply_settings(16'd10, 16'd400, 7'd13, 7'd90);
    repeat (100) press_action(1'($urandom_range(0, 1)));
    settle();
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duties.size() == 0) begin
        report_mismatch("result with no item pending", 1, 0);
      end else begin
        head = pending_duties.pop_front();
        if (out_red_duty !== head.red)
          report_mismatch("red_duty", out_red_duty, head.red);
        if (out_green_duty !== head.green)
          report_mismatch("green_duty", out_green_duty, head.green);
        if (out_blue_duty !== head.blue)
          report_mismatch("blue_duty", out_blue_duty, head.blue);
        if (out_selected_channel !== head.sel)
          report_mismatch("selected_channel", out_selected_channel, head.sel);
        if (out_edge_accepted !== head.accepted)
          report_mismatch("edge_accepted", out_edge_accepted, head.accepted);
      end
    end
  end

  initial begin
    reset_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_behaviour();
    test_time_wrap();
    test_press_sequences();
    test_steady_stream();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
